[sv/swm_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the sliding-window median filter.
package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int SAMPLE_W   = 32;
    localparam int MEDIAN_W   = SAMPLE_W + 1;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SIZE_W     = 7;

    // Operation broadcast to all cells of the row in the same cycle.
    typedef struct packed {
        logic                       clr;
        logic                       ins;
        logic                       rem;
        logic                       restart;
        logic signed [SAMPLE_W-1:0] key;
    } swm_op_t;

endpackage

[sv/swm_cell.sv]
`timescale 1ns / 1ps
// One cell of the sorted row: holds one sample and its valid flag.
module swm_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  swm_pkg::swm_op_t                    op,
    input  logic                                left_vld,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] left_val,
    input  logic                                left_m,
    input  logic                                right_vld,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] right_val,
    output logic                                m_out,
    output logic                                vld_out,
    output logic signed [swm_pkg::SAMPLE_W-1:0] val_out
);

    logic                                vld_reg;
    logic                                vld_next;
    logic signed [swm_pkg::SAMPLE_W-1:0] val_reg;
    logic signed [swm_pkg::SAMPLE_W-1:0] val_next;
    logic                                vld_eff;
    logic                                gone;

    // a restart empties the row before the new sample goes in
    assign vld_eff = vld_reg & ~op.restart;
    // insert position: first slot that is empty or holds a larger value
    assign m_out   = ~vld_eff | (val_reg > op.key);
    // removal: this slot and all above shift down past the first equal value
    assign gone    = vld_reg & (val_reg >= op.key);

    assign vld_out = vld_eff;
    assign val_out = val_reg;

    always_comb
    begin
        vld_next = vld_reg;
        val_next = val_reg;
        if (op.clr)
        begin
            vld_next = 1'b0;
        end
        else if (op.ins)
        begin
            if (left_m)
            begin
                vld_next = left_vld;
                val_next = left_val;
            end
            else if (m_out)
            begin
                vld_next = 1'b1;
                val_next = op.key;
            end
            else
            begin
                vld_next = vld_eff;
            end
        end
        else if (op.rem && gone)
        begin
            vld_next = right_vld;
            val_next = right_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[sv/swm_chain.sv]
`timescale 1ns / 1ps
// Row of sorted cells with the two middle-tap selectors.
module swm_chain (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  swm_pkg::swm_op_t                     op,
    input  logic [swm_pkg::IDX_W-1:0]            sel_lo,
    input  logic [swm_pkg::IDX_W-1:0]            sel_hi,
    output logic signed [swm_pkg::SAMPLE_W-1:0]  lo_val,
    output logic signed [swm_pkg::SAMPLE_W-1:0]  hi_val,
    output logic [swm_pkg::WINDOW_MAX-1:0]       vld
);

    logic [swm_pkg::WINDOW_MAX-1:0]              m;
    logic signed [swm_pkg::SAMPLE_W-1:0]         val [swm_pkg::WINDOW_MAX];

    for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++)
    begin : g_cell
        logic                                left_vld;
        logic signed [swm_pkg::SAMPLE_W-1:0] left_val;
        logic                                left_m;
        logic                                right_vld;
        logic signed [swm_pkg::SAMPLE_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_vld = 1'b0;
            assign left_val = '0;
            assign left_m   = 1'b0;
        end
        else
        begin : g_mid
            assign left_vld = vld[i-1];
            assign left_val = val[i-1];
            assign left_m   = m[i-1];
        end

        if (i == swm_pkg::WINDOW_MAX - 1)
        begin : g_last
            assign right_vld = 1'b0;
            assign right_val = '0;
        end
        else
        begin : g_inner
            assign right_vld = vld[i+1];
            assign right_val = val[i+1];
        end

        swm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op),
            .left_vld  (left_vld),
            .left_val  (left_val),
            .left_m    (left_m),
            .right_vld (right_vld),
            .right_val (right_val),
            .m_out     (m[i]),
            .vld_out   (vld[i]),
            .val_out   (val[i])
        );
    end

    // one-hot tap select, folded as an OR tree
    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < swm_pkg::WINDOW_MAX; i++)
        begin
            if (sel_lo == i[swm_pkg::IDX_W-1:0])
            begin
                lo_val = lo_val | val[i];
            end
            if (sel_hi == i[swm_pkg::IDX_W-1:0])
            begin
                hi_val = hi_val | val[i];
            end
        end
    end

endmodule

[sv/sliding_window_median_top.sv]
`timescale 1ns / 1ps
// Top level of the sliding-window median filter: control, arrival ring and output register.
// A sample that does not fill the window is taken and the block stays ready for the next
// one; a sample that fills it is inserted into the sorted row of cells, then goes through
// the middle-tap select with removal of the oldest sample, then the sum into the output
// register, and no new sample is taken until then; the emit stage holds while the previous
// output beat waits for out_ready. The sorted row shifts all cells at once, so these steps
// do not depend on the window size.
// Writing window_size empties the window; it must only be written while the block is idle.
module sliding_window_median_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [swm_pkg::SIZE_W-1:0]             cfg_wr_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [swm_pkg::SAMPLE_W-1:0]    sample,
    input  logic                                   restart,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [swm_pkg::MEDIAN_W-1:0]    median_x2
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MED,
        S_EMIT
    } state_t;

    state_t                                state_reg;
    logic [swm_pkg::SIZE_W-1:0]            eff_reg;
    logic [swm_pkg::IDX_W-1:0]             lo_idx_reg;
    logic [swm_pkg::IDX_W-1:0]             hi_idx_reg;
    logic [swm_pkg::CNT_W-1:0]             fill_reg;
    logic [swm_pkg::IDX_W-1:0]             ptr_reg;
    logic                                  out_valid_reg;
    logic signed [swm_pkg::MEDIAN_W-1:0]   median_reg;
    logic signed [swm_pkg::SAMPLE_W-1:0]   lo_reg;
    logic signed [swm_pkg::SAMPLE_W-1:0]   hi_reg;
    logic signed [swm_pkg::SAMPLE_W-1:0]   old_reg;

    logic signed [swm_pkg::SAMPLE_W-1:0]   ring [swm_pkg::WINDOW_MAX];

    logic                                  acc;
    logic [swm_pkg::CNT_W-1:0]             base_fill;
    logic [swm_pkg::IDX_W-1:0]             base_ptr;
    logic [swm_pkg::IDX_W-1:0]             wslot;
    logic [swm_pkg::CNT_W-1:0]             fill_ins;
    logic                                  full;
    logic [swm_pkg::SIZE_W-1:0]            eff_next;
    logic [swm_pkg::SIZE_W-1:0]            eff_m1;
    swm_pkg::swm_op_t                      op;
    logic signed [swm_pkg::SAMPLE_W-1:0]   lo_val;
    logic signed [swm_pkg::SAMPLE_W-1:0]   hi_val;
    logic [swm_pkg::WINDOW_MAX-1:0]        cell_vld;

    assign in_ready  = (state_reg == S_IDLE);
    assign acc       = in_valid & in_ready;
    assign out_valid = out_valid_reg;
    assign median_x2 = median_reg;

    assign base_fill = restart ? '0 : fill_reg;
    assign base_ptr  = restart ? '0 : ptr_reg;
    assign wslot     = base_ptr + base_fill[swm_pkg::IDX_W-1:0];
    assign fill_ins  = base_fill + swm_pkg::CNT_W'(1);
    assign full      = fill_ins >= eff_reg;

    // zero counts as one, oversize saturates at the row length
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            eff_next = swm_pkg::SIZE_W'(1);
        end
        else if (cfg_wr_data > swm_pkg::SIZE_W'(swm_pkg::WINDOW_MAX))
        begin
            eff_next = swm_pkg::SIZE_W'(swm_pkg::WINDOW_MAX);
        end
        else
        begin
            eff_next = cfg_wr_data;
        end
        eff_m1 = eff_next - swm_pkg::SIZE_W'(1);
    end

    always_comb
    begin
        op.clr     = cfg_wr_en;
        op.ins     = acc;
        op.restart = acc & restart;
        op.rem     = (state_reg == S_MED);
        op.key     = acc ? sample : old_reg;
    end

    swm_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .sel_lo (lo_idx_reg),
        .sel_hi (hi_idx_reg),
        .lo_val (lo_val),
        .hi_val (hi_val),
        .vld    (cell_vld)
    );

    // arrival ring, write-first so a one-sample window sees its own beat as oldest
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ring[wslot] <= sample;
            if (wslot == base_ptr)
            begin
                old_reg <= sample;
            end
            else
            begin
                old_reg <= ring[base_ptr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MED)
        begin
            lo_reg <= lo_val;
            hi_reg <= hi_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            eff_reg       <= swm_pkg::SIZE_W'(3);
            lo_idx_reg    <= swm_pkg::IDX_W'(1);
            hi_idx_reg    <= swm_pkg::IDX_W'(1);
            fill_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            median_reg    <= '0;
        end
        else
        begin
            // the emit stage drives valid itself
            if (out_valid_reg && out_ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_wr_en)
                    begin
                        eff_reg    <= eff_next;
                        lo_idx_reg <= eff_m1[swm_pkg::IDX_W:1];
                        hi_idx_reg <= eff_next[swm_pkg::IDX_W:1];
                        fill_reg   <= '0;
                        ptr_reg    <= '0;
                    end
                    else if (acc)
                    begin
                        if (full)
                        begin
                            // window complete: emit, then drop the oldest
                            fill_reg  <= fill_ins - swm_pkg::CNT_W'(1);
                            ptr_reg   <= base_ptr + swm_pkg::IDX_W'(1);
                            state_reg <= S_MED;
                        end
                        else
                        begin
                            fill_reg <= fill_ins;
                            ptr_reg  <= base_ptr;
                        end
                    end
                end
                S_MED:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // hold while the previous beat is still waiting
                    if (!out_valid_reg || out_ready)
                    begin
                        median_reg    <= swm_pkg::MEDIAN_W'(lo_reg) + swm_pkg::MEDIAN_W'(hi_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_fill_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < swm_pkg::CNT_W'(eff_reg))
        else $error("fill count reached window size");

    a_cells_match_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !op.restart) |-> ($countones(cell_vld) == int'(fill_reg)))
        else $error("sorted row occupancy differs from fill count");

    a_med_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MED) |=> (state_reg == S_EMIT))
        else $error("median select not followed by emit");

    a_full_goes_med: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !cfg_wr_en && full) |=> (state_reg == S_MED))
        else $error("full window did not start median select");

endmodule
